/* hdl/puct_pkg.sv */
// Shared types and constants for the pending update coalescing table.
package puct_pkg;

    localparam int ID_W    = 22;
    localparam int SCORE_W = 11;
    localparam int STAT_W  = 2;
    localparam int CIDX_W  = 2;

    // entry layout: {process id, background, pending}
    localparam int ENTRY_W = ID_W + 2;

    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL    = 2'd1;
    localparam logic [STAT_W-1:0] STAT_IGNORED = 2'd2;
    localparam logic [STAT_W-1:0] STAT_EMPTY   = 2'd3;

    localparam logic CMD_UPDATE = 1'b0;
    localparam logic CMD_TAKE   = 1'b1;

    localparam logic [CIDX_W-1:0] CFG_ENABLE    = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_THRESHOLD = 2'd1;

    localparam logic                      ENABLE_RST    = 1'b1;
    localparam logic signed [SCORE_W-1:0] THRESHOLD_RST = 11'sd100;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_DONE
    } t_state;

endpackage

/* hdl/pending_update_coalesce_table_unit.sv */
// Pending update coalescing table: slot memory, scan sequencer and result register.
//
// Input channel (i_in_valid / o_in_stall) carries one transaction per item:
// i_command selects update (0) or take (1). Output channel (o_out_valid /
// i_out_stall) returns exactly one result per item, held in an output
// register until taken. Configuration writes (i_cfg_valid / o_cfg_ready)
// update enable (index 0) and score_threshold (index 1); ready is always high.
// An ignored update skips the scan and goes straight to the result. Every other
// item scans all slots through one compare unit, one slot per cycle from a
// registered memory read, then a decide step writes the slot and the result.
// One item is in work at a time; the next is accepted once the result has
// moved into the output register, which may still be waiting on the receiver.
// While the receiver stalls, the output holds and a finished item waits.
// Reset: a clearing pass over all slots zeroes the slot memory; the
// input stalls for its duration, configuration writes are taken meanwhile.
module pending_update_coalesce_table_unit #(
    parameter int SLOT_COUNT = 256
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic                                  i_command,
    input  logic [puct_pkg::ID_W-1:0]             i_process_id,
    input  logic signed [puct_pkg::SCORE_W-1:0]   i_score_adj,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic [puct_pkg::STAT_W-1:0]           o_status,
    output logic [puct_pkg::ID_W-1:0]             o_out_process_id,
    output logic                                  o_out_background,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [puct_pkg::CIDX_W-1:0]           i_cfg_index,
    input  logic [puct_pkg::SCORE_W-1:0]          i_cfg_data
);

    localparam int IW    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W = IW + 1;
    localparam int ID_W  = puct_pkg::ID_W;
    localparam int EW    = puct_pkg::ENTRY_W;

    puct_pkg::t_state r_state, n_state;

    logic                                r_enable;
    logic signed [puct_pkg::SCORE_W-1:0] r_threshold;

    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_rd_vld;
    logic [IW-1:0]    r_rd_idx;
    logic [EW-1:0]    r_rd_data;
    logic [EW-1:0]    mem [SLOT_COUNT];

    logic             mem_we;
    logic [IW-1:0]    mem_waddr;
    logic [EW-1:0]    mem_wdata;

    // current item
    logic             r_cmd;
    logic [ID_W-1:0]  r_id;
    logic             r_bg;

    // scan trackers
    logic             r_hit_found, r_hit_bg, r_hit_pend;
    logic [IW-1:0]    r_hit_idx;
    logic             r_free_found;
    logic [IW-1:0]    r_free_idx;
    logic             r_idle_found;
    logic [IW-1:0]    r_idle_idx;
    logic             r_pend_found, r_pend_bg;
    logic [IW-1:0]    r_pend_idx;
    logic [ID_W-1:0]  r_pend_id;

    // pending result
    logic [puct_pkg::STAT_W-1:0] r_res_status, n_res_status;
    logic [ID_W-1:0]             r_res_id, n_res_id;
    logic                        r_res_bg, n_res_bg;

    logic [puct_pkg::STAT_W-1:0] r_out_status;
    logic [ID_W-1:0]             r_out_id;
    logic                        r_out_bg;
    logic                        r_out_valid;

    logic             in_acc;
    logic             out_load;
    logic             in_ignored;
    logic [ID_W-1:0]  d_id;
    logic             d_bg, d_pend;
    logic             id_eq;

    assign in_acc     = i_in_valid && !o_in_stall;
    assign in_ignored = (i_command == puct_pkg::CMD_UPDATE) &&
                        (!r_enable || (i_process_id == '0));
    assign d_id       = r_rd_data[EW-1:2];
    assign d_bg       = r_rd_data[1];
    assign d_pend     = r_rd_data[0];
    assign id_eq      = (d_id == r_id);   // the shared compare unit
    assign out_load   = (r_state == puct_pkg::S_DONE) && (!r_out_valid || !i_out_stall);

    assign o_in_stall       = (r_state != puct_pkg::S_IDLE);
    assign o_cfg_ready      = 1'b1;
    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out_status;
    assign o_out_process_id = r_out_id;
    assign o_out_background = r_out_bg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= puct_pkg::S_CLEAR;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        mem_we       = 1'b0;
        mem_waddr    = r_cnt[IW-1:0];
        mem_wdata    = '0;
        n_res_status = r_res_status;
        n_res_id     = r_res_id;
        n_res_bg     = r_res_bg;
        case (r_state)
            puct_pkg::S_CLEAR: begin
                mem_we = 1'b1;
                n_cnt  = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(SLOT_COUNT - 1)) begin
                    n_state = puct_pkg::S_IDLE;
                end
            end
            puct_pkg::S_IDLE: begin
                n_cnt = '0;
                if (in_acc) begin
                    if (in_ignored) begin
                        n_res_status = puct_pkg::STAT_IGNORED;
                        n_res_id     = '0;
                        n_res_bg     = 1'b0;
                        n_state      = puct_pkg::S_DONE;
                    end else begin
                        n_state = puct_pkg::S_SCAN;
                    end
                end
            end
            puct_pkg::S_SCAN: begin
                if (r_cnt == CNT_W'(SLOT_COUNT)) begin
                    // last read data is folded into the trackers this cycle
                    n_state = puct_pkg::S_DECIDE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            puct_pkg::S_DECIDE: begin
                n_state  = puct_pkg::S_DONE;
                n_res_id = '0;
                n_res_bg = 1'b0;
                if (r_cmd == puct_pkg::CMD_TAKE) begin
                    if (r_pend_found) begin
                        mem_we       = 1'b1;
                        mem_waddr    = r_pend_idx;
                        mem_wdata    = {r_pend_id, r_pend_bg, 1'b0};
                        n_res_status = puct_pkg::STAT_OK;
                        n_res_id     = r_pend_id;
                        n_res_bg     = r_pend_bg;
                    end else begin
                        n_res_status = puct_pkg::STAT_EMPTY;
                    end
                end else begin
                    mem_wdata    = {r_id, r_bg, 1'b1};
                    n_res_status = puct_pkg::STAT_OK;
                    if (r_hit_found) begin
                        // unchanged and not pending: leave the slot alone
                        mem_we    = (r_hit_bg != r_bg) || r_hit_pend;
                        mem_waddr = r_hit_idx;
                    end else if (r_free_found) begin
                        mem_we    = 1'b1;
                        mem_waddr = r_free_idx;
                    end else if (r_idle_found) begin
                        mem_we    = 1'b1;
                        mem_waddr = r_idle_idx;
                    end else begin
                        n_res_status = puct_pkg::STAT_FULL;
                    end
                end
            end
            puct_pkg::S_DONE: begin
                if (out_load) begin
                    n_state = puct_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = puct_pkg::S_IDLE;
            end
        endcase
    end

    // slot memory, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= mem[r_cnt[IW-1:0]];
        r_rd_idx  <= r_cnt[IW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= (r_state == puct_pkg::S_SCAN) && (r_cnt != CNT_W'(SLOT_COUNT));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable    <= puct_pkg::ENABLE_RST;
            r_threshold <= puct_pkg::THRESHOLD_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                puct_pkg::CFG_ENABLE:    r_enable    <= i_cfg_data[0];
                puct_pkg::CFG_THRESHOLD: r_threshold <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    // item capture and scan trackers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd        <= i_command;
            r_id         <= i_process_id;
            r_bg         <= (i_score_adj >= r_threshold);
            r_hit_found  <= 1'b0;
            r_free_found <= 1'b0;
            r_idle_found <= 1'b0;
            r_pend_found <= 1'b0;
        end else if ((r_state == puct_pkg::S_SCAN) && r_rd_vld) begin
            if (!r_hit_found && id_eq) begin
                r_hit_found <= 1'b1;
                r_hit_idx   <= r_rd_idx;
                r_hit_bg    <= d_bg;
                r_hit_pend  <= d_pend;
            end
            if (!r_free_found && (d_id == '0)) begin
                r_free_found <= 1'b1;
                r_free_idx   <= r_rd_idx;
            end
            if (!r_idle_found && !d_pend) begin
                r_idle_found <= 1'b1;
                r_idle_idx   <= r_rd_idx;
            end
            if (!r_pend_found && d_pend) begin
                r_pend_found <= 1'b1;
                r_pend_idx   <= r_rd_idx;
                r_pend_id    <= d_id;
                r_pend_bg    <= d_bg;
            end
        end
        r_res_status <= n_res_status;
        r_res_id     <= n_res_id;
        r_res_bg     <= n_res_bg;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_status <= r_res_status;
            r_out_id     <= r_res_id;
            r_out_bg     <= r_res_bg;
        end
    end

    a_no_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == puct_pkg::S_SCAN) |-> !mem_we)
        else $error("slot memory written during scan");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == puct_pkg::S_DONE))
        else $error("result appeared without a finished item");

    a_hit_slot_reused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == puct_pkg::S_DECIDE && r_cmd == puct_pkg::CMD_UPDATE &&
         r_hit_found && mem_we) |-> (mem_waddr == r_hit_idx))
        else $error("update with matching id wrote another slot");

    a_clear_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == puct_pkg::S_CLEAR) |-> (o_in_stall && mem_we))
        else $error("input open or memory idle during clearing pass");

    a_non_take_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != puct_pkg::STAT_OK) |->
        (o_out_process_id == '0 && !o_out_background))
        else $error("non-entry result carries entry data");

endmodule
